>>> rtl/core/cki_pkg.sv
package cki_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int RULE_SLOTS    = 16;

  localparam int TBL_IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TBL_CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int RULE_IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int RULE_CW = $clog2(RULE_SLOTS + 1);

  localparam int ADDR_W  = 64;
  localparam int PCT_W   = 7;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int CIDX_W  = 7;

  localparam logic [PCT_W-1:0] DEFAULT_PCT_RST = PCT_W'(50);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic KIND_INDEX   = 1'b0;
  localparam logic KIND_ADDRESS = 1'b1;

  localparam logic [0:0] REG_DEFAULT_PCT = 1'b0;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] caller_address;
    logic [PCT_W-1:0]  random_percent;
    logic [SLOT_W-1:0] rule_slot;
    logic              rule_by_address;
    logic [ADDR_W-1:0] rule_key;
    logic [PCT_W-1:0]  rule_first_percent;
    logic [PCT_W-1:0]  rule_later_percent;
  } in_req_t;

  typedef struct packed {
    logic              fail;
    logic [CIDX_W-1:0] caller_index;
    logic              index_valid;
    logic [CNT_W-1:0]  hit_count;
  } out_rsp_t;

  typedef struct packed {
    logic              done;
    logic              valid;
    logic [TBL_IW-1:0] idx;
    logic [CNT_W-1:0]  count;
  } tbl_res_t;

  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic              by_address;
    logic [ADDR_W-1:0] key;
    logic [PCT_W-1:0]  first_pct;
    logic [PCT_W-1:0]  later_pct;
  } rule_load_t;

endpackage

>>> rtl/core/cki_caller_table.sv
module cki_caller_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cki_pkg::ADDR_W-1:0] key,
  output cki_pkg::tbl_res_t         res
);
  import cki_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0]  cnt_mem  [TABLE_ENTRIES];
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  cnt_q;

  state_t            state_r, state_nxt;
  logic [TBL_CW-1:0] used_r, used_nxt;
  logic [TBL_CW-1:0] issue_r, issue_nxt;
  logic [TBL_IW-1:0] rd_idx_r, rd_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  tbl_res_t          res_r, res_nxt;

  logic              rd_en;
  logic              wr_en;
  logic [TBL_IW-1:0] wr_idx;
  logic [CNT_W-1:0]  wr_cnt;
  logic              hit;
  logic [CNT_W-1:0]  cnt_inc;

  assign hit     = rd_pend_r && (addr_q == key);
  assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    issue_nxt   = issue_r;
    rd_idx_nxt  = rd_idx_r;
    rd_pend_nxt = 1'b0;
    res_nxt     = res_r;
    res_nxt.done = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = rd_idx_r;
    wr_cnt      = cnt_inc;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          issue_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_en         = 1'b1;
          res_nxt.valid = 1'b1;
          res_nxt.idx   = rd_idx_r;
          res_nxt.count = cnt_inc;
          state_nxt     = S_DONE;
        end else if (issue_r < used_r) begin
          rd_en       = 1'b1;
          rd_idx_nxt  = issue_r[TBL_IW-1:0];
          rd_pend_nxt = 1'b1;
          issue_nxt   = issue_r + TBL_CW'(1);
        end else begin
          if (used_r < TBL_CW'(TABLE_ENTRIES)) begin
            wr_en         = 1'b1;
            wr_idx        = used_r[TBL_IW-1:0];
            wr_cnt        = CNT_W'(1);
            used_nxt      = used_r + TBL_CW'(1);
            res_nxt.valid = 1'b1;
            res_nxt.idx   = used_r[TBL_IW-1:0];
            res_nxt.count = CNT_W'(1);
          end else begin
            res_nxt.valid = 1'b0;
            res_nxt.idx   = '0;
            res_nxt.count = '0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_nxt.done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= key;
      cnt_mem[wr_idx]  <= wr_cnt;
    end
    if (rd_en) begin
      addr_q <= addr_mem[issue_r[TBL_IW-1:0]];
      cnt_q  <= cnt_mem[issue_r[TBL_IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      issue_r   <= '0;
      rd_pend_r <= 1'b0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      issue_r   <= issue_nxt;
      rd_pend_r <= rd_pend_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
  end

  assign res = res_r;

endmodule

>>> rtl/core/cki_rule_engine.sv
module cki_rule_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cki_pkg::rule_load_t         ld,
  input  logic                        start,
  input  logic [cki_pkg::ADDR_W-1:0]  addr,
  input  logic                        idx_valid,
  input  logic [cki_pkg::TBL_IW-1:0]  idx,
  input  logic [cki_pkg::PCT_W-1:0]   rnd,
  input  logic [cki_pkg::PCT_W-1:0]   default_pct,
  output logic                        done,
  output logic                        fail
);
  import cki_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  logic              rule_valid_r [RULE_SLOTS];
  logic              rule_kind_r  [RULE_SLOTS];
  logic [ADDR_W-1:0] rule_key_r   [RULE_SLOTS];
  logic [PCT_W-1:0]  rule_cur_r   [RULE_SLOTS];
  logic [PCT_W-1:0]  rule_next_r  [RULE_SLOTS];

  state_t             state_r;
  logic [RULE_CW-1:0] slot_r;
  logic               done_r;
  logic               fail_r;

  logic [RULE_IW-1:0] cur;
  logic [RULE_IW-1:0] ld_slot;
  logic               ld_ok;
  logic               match;
  logic               upd;

  assign cur     = slot_r[RULE_IW-1:0];
  assign ld_slot = RULE_IW'(ld.slot);
  assign ld_ok   = ld.load && (32'(ld.slot) < RULE_SLOTS);
  assign match   = rule_valid_r[cur] &&
                   ((rule_kind_r[cur] == KIND_ADDRESS) ? (rule_key_r[cur] == addr)
                                                       : (idx_valid &&
                                                          rule_key_r[cur] == ADDR_W'(idx)));
  assign upd     = (state_r == S_SCAN) && (slot_r < RULE_CW'(RULE_SLOTS)) && match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        rule_valid_r[i] <= 1'b0;
      end
    end else if (ld_ok) begin
      rule_valid_r[ld_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ok) begin
      rule_kind_r[ld_slot] <= ld.by_address;
      rule_key_r[ld_slot]  <= ld.key;
      rule_cur_r[ld_slot]  <= ld.first_pct;
      rule_next_r[ld_slot] <= ld.later_pct;
    end else if (upd) begin
      rule_cur_r[cur] <= rule_next_r[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      done_r  <= 1'b0;
      fail_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            slot_r  <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (slot_r >= RULE_CW'(RULE_SLOTS)) begin
            fail_r  <= rnd < default_pct;
            state_r <= S_DONE;
          end else if (match) begin
            fail_r  <= rnd < rule_cur_r[cur];
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + RULE_CW'(1);
          end
        end
        S_DONE: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign fail = fail_r;

endmodule

>>> rtl/core/caller_keyed_fault_injector_unit.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall  | cki_pkg::in_req_t
// out_    | output    | out_valid / out_stall| cki_pkg::out_rsp_t
// cfg_    | input     | APB, pready high     | default_fail_percent at 0x0
//
// A rule load writes its slot at accept and then passes through S_OUT to the
// result register. A request scans the caller memory, one entry per cycle
// through a registered read, then the rule slots one per cycle, and its
// result goes through S_OUT to the result register. One request is in work
// at a time; the result register lets the next request in while a result
// waits under out_stall.
// Synchronous reset clears the entry count, rule valid bits and result valid.
module caller_keyed_fault_injector_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cki_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cki_pkg::out_rsp_t  out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import cki_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TBL, S_RULE_GO, S_RULE, S_OUT} state_t;

  state_t           state_r;
  in_req_t          req_r;
  out_rsp_t         rsp_r;
  out_rsp_t         out_r;
  logic             out_valid_r;
  logic [PCT_W-1:0] default_pct_r;

  logic       accept;
  logic       cfg_wr;
  logic       tbl_start;
  logic       rule_start;
  logic       rule_done;
  logic       rule_fail;
  logic       out_free;
  tbl_res_t   tbl_res;
  rule_load_t ld;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_DEFAULT_PCT) ? 32'(default_pct_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_pct_r <= DEFAULT_PCT_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_DEFAULT_PCT) begin
      default_pct_r <= cfg_pwdata[PCT_W-1:0];
    end
  end

  assign ld.load       = accept && (in_data.operation == OP_LOAD);
  assign ld.slot       = in_data.rule_slot;
  assign ld.by_address = in_data.rule_by_address;
  assign ld.key        = in_data.rule_key;
  assign ld.first_pct  = in_data.rule_first_percent;
  assign ld.later_pct  = in_data.rule_later_percent;

  assign tbl_start  = (state_r == S_IDLE) && accept && (in_data.operation == OP_ALLOC);
  assign rule_start = (state_r == S_RULE_GO);

  cki_caller_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tbl_start),
    .key   (req_r.caller_address),
    .res   (tbl_res)
  );

  cki_rule_engine u_rules (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (ld),
    .start       (rule_start),
    .addr        (req_r.caller_address),
    .idx_valid   (rsp_r.index_valid),
    .idx         (TBL_IW'(rsp_r.caller_index)),
    .rnd         (req_r.random_percent),
    .default_pct (default_pct_r),
    .done        (rule_done),
    .fail        (rule_fail)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      rsp_r <= '0;
    end else if (state_r == S_TBL && tbl_res.done) begin
      rsp_r.index_valid  <= tbl_res.valid;
      rsp_r.caller_index <= CIDX_W'(tbl_res.idx);
      rsp_r.hit_count    <= tbl_res.count;
    end else if (state_r == S_RULE && rule_done) begin
      rsp_r.fail <= rule_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_r <= rsp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (in_data.operation == OP_LOAD) ? S_OUT : S_TBL;
          end
        end
        S_TBL: begin
          if (tbl_res.done) begin
            state_r <= S_RULE_GO;
          end
        end
        S_RULE_GO: state_r <= S_RULE;
        S_RULE: begin
          if (rule_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cki_pkg::*;

  localparam int unsigned LIMIT = 2_000_000;
  localparam logic [2:0] DEFAULT_PCT_ADDR = 3'(4 * REG_DEFAULT_PCT);
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef struct {
    in_req_t  req;
    bit       fixed;
    out_rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // predictor state
  logic [ADDR_W-1:0] caller_tbl [TABLE_ENTRIES];
  logic [CNT_W-1:0] caller_hits [TABLE_ENTRIES];
  int unsigned callers_known = 0;
  bit rule_on [RULE_SLOTS];
  logic rule_by_addr [RULE_SLOTS];
  logic [ADDR_W-1:0] rule_match [RULE_SLOTS];
  logic [PCT_W-1:0] pct_now [RULE_SLOTS];
  logic [PCT_W-1:0] pct_after [RULE_SLOTS];
  logic [PCT_W-1:0] dflt_pct = DEFAULT_PCT_RST;

  out_rsp_t verdict_q [$];
  row_t pinned_q [$];
  row_t directed [$];
  logic [ADDR_W-1:0] caller_pool [$];
  int unsigned requests_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_hold = 0;
  bit no_idle = 1'b0;

  int unsigned pct_plan [8] = '{0, 100, 127, 1, 99, 0, 50, 64};
  logic [ADDR_W-1:0] ones = '1;
  logic [ADDR_W-1:0] fives = 64'h5555_5555_5555_5555;
  logic [ADDR_W-1:0] tens = 64'hAAAA_AAAA_AAAA_AAAA;

  caller_keyed_fault_injector_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct();
    if ($urandom_range(0, 4) == 0) return PCT_W'($urandom_range(0, 127));
    return PCT_W'($urandom_range(0, 100));
  endfunction

  function automatic out_rsp_t verdict(logic f, int unsigned idx, logic v, int unsigned cnt);
    out_rsp_t res;
    res.fail = f;
    res.caller_index = CIDX_W'(idx);
    res.index_valid = v;
    res.hit_count = CNT_W'(cnt);
    return res;
  endfunction

  // expected verdict for one request; updates the caller table and rules
  function automatic out_rsp_t injector_verdict(in_req_t r);
    out_rsp_t res;
    bit known;
    bit matched;
    int unsigned pos;
    logic [PCT_W-1:0] lim;
    res = '0;
    if (r.operation == OP_LOAD) begin
      if (r.rule_slot < RULE_SLOTS) begin
        rule_on[r.rule_slot] = 1'b1;
        rule_by_addr[r.rule_slot] = r.rule_by_address;
        rule_match[r.rule_slot] = r.rule_key;
        pct_now[r.rule_slot] = r.rule_first_percent;
        pct_after[r.rule_slot] = r.rule_later_percent;
      end
      return res;
    end
    known = 1'b0;
    pos = 0;
    for (int unsigned n = 0; n < callers_known; n++) begin
      if (!known && caller_tbl[n] == r.caller_address) begin
        known = 1'b1;
        pos = n;
      end
    end
    if (known) begin
      if (caller_hits[pos] != '1) caller_hits[pos]++;
    end else if (callers_known < TABLE_ENTRIES) begin
      pos = callers_known;
      caller_tbl[pos] = r.caller_address;
      caller_hits[pos] = CNT_W'(1);
      callers_known++;
      known = 1'b1;
    end
    lim = dflt_pct;
    matched = 1'b0;
    for (int n = 0; n < RULE_SLOTS; n++) begin
      if (!matched && rule_on[n] &&
          ((rule_by_addr[n] == KIND_ADDRESS) ? (rule_match[n] == r.caller_address)
                                             : (known && rule_match[n] == 64'(pos)))) begin
        matched = 1'b1;
        lim = pct_now[n];
        pct_now[n] = pct_after[n];
      end
    end
    res.fail = r.random_percent < lim;
    if (known) begin
      res.caller_index = CIDX_W'(pos);
      res.index_valid = 1'b1;
      res.hit_count = caller_hits[pos];
    end
    return res;
  endfunction

  function automatic in_req_t noise_item();
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(in_req_t)-1:0];
  endfunction

  function automatic in_req_t alloc_req(logic [ADDR_W-1:0] addr, int unsigned rnd);
    in_req_t r;
    r = noise_item();
    r.operation = OP_ALLOC;
    r.caller_address = addr;
    r.random_percent = PCT_W'(rnd);
    return r;
  endfunction

  function automatic in_req_t load_req(int unsigned slot, logic kind, logic [ADDR_W-1:0] key,
                                       int unsigned first, int unsigned later);
    in_req_t r;
    r = noise_item();
    r.operation = OP_LOAD;
    r.rule_slot = SLOT_W'(slot);
    r.rule_by_address = kind;
    r.rule_key = key;
    r.rule_first_percent = PCT_W'(first);
    r.rule_later_percent = PCT_W'(later);
    return r;
  endfunction

  // mostly repeat callers, some fresh ones; loads aim at known callers and indexes
  function automatic in_req_t random_item();
    in_req_t r;
    r = noise_item();
    if ($urandom_range(0, 9) == 0) begin
      r.operation = OP_LOAD;
      if (r.rule_by_address == KIND_ADDRESS) begin
        if ($urandom_range(0, 3) != 0)
          r.rule_key = caller_pool[$urandom_range(0, caller_pool.size() - 1)];
      end else if ($urandom_range(0, 9) != 0) begin
        r.rule_key = 64'($urandom_range(0, TABLE_ENTRIES - 1));
      end
      r.rule_first_percent = pick_pct();
      r.rule_later_percent = pick_pct();
    end else begin
      r.operation = OP_ALLOC;
      if ($urandom_range(0, 99) < 12) caller_pool.push_back(r.caller_address);
      else r.caller_address = caller_pool[$urandom_range(0, caller_pool.size() - 1)];
      if ($urandom_range(0, 6) != 0) r.random_percent = PCT_W'($urandom_range(0, 99));
    end
    return r;
  endfunction

  task automatic add_row(in_req_t r, bit fixed, out_rsp_t e);
    row_t t;
    t.req = r;
    t.fixed = fixed;
    t.rsp = e;
    directed.push_back(t);
  endtask

  task automatic send(row_t t);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_q.push_back(t);
    in_valid <= 1'b1;
    in_data <= t.req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_taken++;
  endtask

  task automatic drain();
    while (verdicts_seen < requests_taken) @(posedge clk);
  endtask

  task automatic cfg_write_check(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == DEFAULT_PCT_ADDR) dflt_pct = data[PCT_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= DEFAULT_PCT_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== 32'(dflt_pct))
      flag("default percent readback", 64'(cfg_prdata), 64'(dflt_pct));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 2) == 0);
      stall_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin : scoreboard
    out_rsp_t want;
    row_t pin;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          flag("result with no request pending", 64'(out_data), 64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.fail !== want.fail)
            flag("fail", 64'(out_data.fail), 64'(want.fail));
          if (out_data.caller_index !== want.caller_index)
            flag("caller_index", 64'(out_data.caller_index), 64'(want.caller_index));
          if (out_data.index_valid !== want.index_valid)
            flag("index_valid", 64'(out_data.index_valid), 64'(want.index_valid));
          if (out_data.hit_count !== want.hit_count)
            flag("hit_count", 64'(out_data.hit_count), 64'(want.hit_count));
        end
      end
      if (in_valid && !in_stall) begin
        want = injector_verdict(in_data);
        pin = pinned_q.pop_front();
        if (pin.fixed) want = pin.rsp;
        verdict_q.push_back(want);
      end
    end
  end

  initial begin : stimulus
    row_t t;
    int unsigned pct;
    logic [31:0] word;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(alloc_req('0, 0), 1'b1, verdict(1'b1, 0, 1'b1, 1));
    add_row(alloc_req(ones, 127), 1'b1, verdict(1'b0, 1, 1'b1, 1));
    add_row(alloc_req('0, 49), 1'b1, verdict(1'b1, 0, 1'b1, 2));
    add_row(alloc_req(ones, 50), 1'b1, verdict(1'b0, 1, 1'b1, 2));
    add_row(load_req(0, KIND_INDEX, '0, 100, 0), 1'b1, '0);
    add_row(load_req(15, KIND_ADDRESS, ones, 0, 127), 1'b1, '0);
    add_row(load_req(7, KIND_ADDRESS, '0, 127, 127), 1'b1, '0);
    add_row(alloc_req('0, 99), 1'b0, '0);
    add_row(alloc_req('0, 0), 1'b0, '0);
    add_row(alloc_req(ones, 126), 1'b0, '0);
    add_row(alloc_req(ones, 126), 1'b0, '0);
    add_row(load_req(3, KIND_INDEX, 64'h8000_0000_0000_0002, 127, 127), 1'b1, '0);
    add_row(load_req(4, KIND_INDEX, 64'd2, 127, 0), 1'b1, '0);
    add_row(alloc_req(fives, 127), 1'b0, '0);
    add_row(alloc_req(tens, 0), 1'b0, '0);
    add_row(load_req(0, KIND_ADDRESS, tens, 0, 100), 1'b1, '0);
    add_row(alloc_req(tens, 0), 1'b0, '0);
    add_row(alloc_req(tens, 0), 1'b0, '0);
    add_row(alloc_req(fives, 126), 1'b0, '0);
    add_row(load_req(8, KIND_ADDRESS, 64'h1234_5678_9ABC_DEF0, 127, 127), 1'b1, '0);
    add_row(alloc_req('0, 127), 1'b0, '0);

    foreach (directed[i]) send(directed[i]);
    in_valid <= 1'b0;
    drain();

    caller_pool.push_back('0);
    caller_pool.push_back(ones);
    caller_pool.push_back(fives);
    caller_pool.push_back(tens);
    cfg_write_check(SPARE_ADDR, $urandom());

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 2 || ph == 6);
      pct = (ph == 5) ? $urandom_range(0, 127) : pct_plan[ph];
      word = $urandom();
      word[PCT_W-1:0] = PCT_W'(pct);
      cfg_write_check(DEFAULT_PCT_ADDR, word);
      repeat (200) begin
        t.req = random_item();
        t.fixed = 1'b0;
        t.rsp = '0;
        send(t);
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (verdict_q.size() != 0) flag("results never delivered", 64'(verdict_q.size()), 64'd0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cki_pkg.sv
rtl/core/cki_caller_table.sv
rtl/core/cki_rule_engine.sv
rtl/core/caller_keyed_fault_injector_unit.sv
sim/testbench.sv
